// ===== rtl/core/subexp_pkg.sv =====
package subexp_pkg;

  // Default value width (bounds, reference and result)
  localparam int unsigned VALUE_BITS_DEF = 16;

  // The uniform tail is chosen once the remaining range fits in this many buckets of the next size
  localparam int unsigned SUBEXP_MULT = 3;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BIT   = 1'b1
  } subexp_cmd_e;

  // Control part of a registered input request
  typedef struct packed {
    logic        valid;
    subexp_cmd_e cmd;
    logic        coded_bit;
  } subexp_item_ctl_t;

  // Control part of a pending finish request
  typedef struct packed {
    logic valid;
    logic direct;  // empty range: emit the base unchanged
    logic flip;    // reference in the upper half: mirror from the top
  } subexp_fin_ctl_t;

endpackage

// ===== rtl/core/subexp_in_stage.sv =====
module subexp_in_stage import subexp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic                         coded_bit_i,
  input  logic signed [VALUE_BITS-1:0] low_bound_i,
  input  logic signed [VALUE_BITS-1:0] high_bound_i,
  input  logic        [3:0]            exp_k_i,
  input  logic signed [VALUE_BITS-1:0] reference_i,
  input  logic                         take_i,
  output subexp_item_ctl_t             item_o,
  output logic        [3:0]            item_k_o,
  output logic        [VALUE_BITS-1:0] item_lo_o,
  output logic        [VALUE_BITS-1:0] item_hi_m1_o,
  output logic signed [VALUE_BITS:0]   item_mx_o,
  output logic signed [VALUE_BITS:0]   item_r_o
);

  localparam int unsigned VB = VALUE_BITS;

  subexp_item_ctl_t      item_q;
  logic [3:0]            k_q;
  logic [VB-1:0]         lo_q;
  logic [VB-1:0]         hi_m1_q;
  logic signed [VB:0]    mx_q;
  logic signed [VB:0]    r_q;

  logic                  accept;
  logic signed [VB:0]    lo_ext;
  logic signed [VB:0]    hi_ext;
  logic signed [VB:0]    ref_ext;

  // Slot drains when the core takes it, so a new request can enter the same cycle
  assign in_stall_o = item_q.valid & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Range size and reference offset, formed before the register
  assign lo_ext  = {low_bound_i[VB-1], low_bound_i};
  assign hi_ext  = {high_bound_i[VB-1], high_bound_i};
  assign ref_ext = {reference_i[VB-1], reference_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q  <= '0;
      k_q     <= '0;
      lo_q    <= '0;
      hi_m1_q <= '0;
      mx_q    <= '0;
      r_q     <= '0;
    end else begin
      item_q.valid <= accept | (item_q.valid & ~take_i);
      if (accept) begin
        item_q.cmd       <= subexp_cmd_e'(command_i);
        item_q.coded_bit <= coded_bit_i;
        k_q              <= exp_k_i;
        lo_q             <= low_bound_i;
        hi_m1_q          <= high_bound_i - VB'(1);
        mx_q             <= hi_ext - lo_ext;
        r_q              <= ref_ext - lo_ext;
      end
    end
  end

  assign item_o       = item_q;
  assign item_k_o     = k_q;
  assign item_lo_o    = lo_q;
  assign item_hi_m1_o = hi_m1_q;
  assign item_mx_o    = mx_q;
  assign item_r_o     = r_q;

endmodule

// ===== rtl/core/subexp_core.sv =====
module subexp_core import subexp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  subexp_item_ctl_t           item_i,
  input  logic        [3:0]          item_k_i,
  input  logic        [VALUE_BITS-1:0] item_lo_i,
  input  logic        [VALUE_BITS-1:0] item_hi_m1_i,
  input  logic signed [VALUE_BITS:0] item_mx_i,
  input  logic signed [VALUE_BITS:0] item_r_i,
  output logic                       take_o,
  input  logic                       out_ready_i,
  output subexp_fin_ctl_t            fin_o,
  output logic        [VALUE_BITS-1:0] fin_raw_o,
  output logic        [VALUE_BITS-1:0] fin_base_o,
  output logic signed [VALUE_BITS:0] fin_reff_o
);

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned PIW = $clog2(VB + 3);
  localparam int unsigned BBW = ((PIW > 4) ? PIW : 4) + 1;
  localparam int unsigned BLW = $clog2(VB);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_LITERAL,
    PH_NS_HEAD,
    PH_NS_TAIL
  } phase_e;

  // Index of the highest set bit
  function automatic logic [BLW-1:0] msb_index(input logic [VB-1:0] x);
    logic [BLW-1:0] idx;
    idx = '0;
    for (int i = 0; i < int'(VB); i++) begin
      if (x[i]) idx = BLW'(i);
    end
    return idx;
  endfunction

  phase_e               phase_q, phase_d;
  logic [PIW-1:0]       pidx_q, pidx_d;
  logic [VB-1:0]        offset_q, offset_d;
  logic [VB-1:0]        rem_q, rem_d;
  logic [VB-1:0]        acc_q, acc_d;
  logic [BLW-1:0]       bl_q, bl_d;
  logic [VB-1:0]        thr_q, thr_d;
  logic [3:0]           k_q, k_d;
  logic [VB-1:0]        job_base_q, job_base_d;
  logic                 job_flip_q, job_flip_d;
  logic signed [VB:0]   job_reff_q, job_reff_d;

  subexp_fin_ctl_t      fin_q;
  logic [VB-1:0]        fin_raw_q;
  logic [VB-1:0]        fin_base_q;
  logic signed [VB:0]   fin_reff_q;

  logic                 s2_free;
  logic                 take;
  logic                 emit;
  logic                 direct;
  logic [VB-1:0]        raw_d;

  logic                 do_decide;
  logic [VB-1:0]        dec_rem;
  logic [VB-1:0]        dec_offset;
  logic [BBW-1:0]       dec_b2;
  logic                 dec_big;
  logic [VB+1:0]        dec_a;
  logic                 dec_ns;
  logic [BLW-1:0]       dec_hb;
  logic [VB-1:0]        dec_thr;

  logic [BBW-1:0]       cur_b2;
  logic [VB-1:0]        cur_a;
  logic                 st_flip;
  logic signed [VB:0]   st_reff;
  logic [VB-1:0]        acc_n;
  logic [BLW-1:0]       bl_n;
  logic [VB:0]          tail_sum;

  assign s2_free = ~fin_q.valid | out_ready_i;
  assign take    = item_i.valid & s2_free;
  assign take_o  = s2_free;

  // Current bucket width and size
  assign cur_b2 = (pidx_q == '0) ? BBW'(k_q) : BBW'(k_q) + BBW'(pidx_q) - BBW'(1);
  assign cur_a  = VB'(1) << cur_b2;

  // Recentering setup for a new job
  assign st_flip = $signed({item_r_i, 1'b0}) > $signed({item_mx_i[VB], item_mx_i});
  assign st_reff = item_mx_i - item_r_i - (VB+1)'(1);

  // Bit shift for literal and uniform parts
  assign acc_n    = {acc_q[VB-2:0], item_i.coded_bit};
  assign bl_n     = bl_q - BLW'(1);
  assign tail_sum = {1'b0, offset_q} + {acc_q, 1'b0} - {1'b0, thr_q}
                    + (VB+1)'(item_i.coded_bit);

  // Escape or uniform tail decision
  assign dec_big = dec_b2 >= BBW'(VB);
  assign dec_a   = (VB+2)'(1) << dec_b2;
  assign dec_ns  = dec_big || ({2'b00, dec_rem} <= dec_a * (VB+2)'(SUBEXP_MULT));
  assign dec_hb  = msb_index(dec_rem);
  assign dec_thr = VB'(((VB+1)'(2) << dec_hb) - {1'b0, dec_rem});

  // Next-state logic for one request
  always_comb begin
    phase_d    = phase_q;
    pidx_d     = pidx_q;
    offset_d   = offset_q;
    rem_d      = rem_q;
    acc_d      = acc_q;
    bl_d       = bl_q;
    thr_d      = thr_q;
    k_d        = k_q;
    job_base_d = job_base_q;
    job_flip_d = job_flip_q;
    job_reff_d = job_reff_q;
    emit       = 1'b0;
    direct     = 1'b0;
    raw_d      = '0;
    do_decide  = 1'b0;
    dec_rem    = rem_q;
    dec_offset = offset_q;
    dec_b2     = cur_b2;

    if (item_i.cmd == CMD_START) begin
      pidx_d = '0;
      acc_d  = '0;
      bl_d   = '0;
      k_d    = item_k_i;
      if (item_mx_i[VB] || (item_mx_i == '0)) begin
        // empty range: emit the lower bound
        job_base_d = item_lo_i;
        job_flip_d = 1'b0;
        job_reff_d = '0;
        emit       = 1'b1;
        direct     = 1'b1;
        phase_d    = PH_IDLE;
      end else begin
        job_flip_d = st_flip;
        job_reff_d = st_flip ? st_reff : item_r_i;
        job_base_d = st_flip ? item_hi_m1_i : item_lo_i;
        dec_rem    = item_mx_i[VB-1:0];
        dec_offset = '0;
        dec_b2     = BBW'(item_k_i);
        do_decide  = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_PREFIX: begin
          if (item_i.coded_bit) begin
            dec_offset = offset_q + cur_a;
            dec_rem    = rem_q - cur_a;
            dec_b2     = BBW'(k_q) + BBW'(pidx_q);
            pidx_d     = pidx_q + PIW'(1);
            do_decide  = 1'b1;
          end else if (cur_b2 == '0) begin
            emit    = 1'b1;
            raw_d   = offset_q;
            phase_d = PH_IDLE;
          end else begin
            bl_d    = BLW'(cur_b2);
            acc_d   = '0;
            phase_d = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          acc_d = acc_n;
          bl_d  = bl_n;
          if (bl_n == '0) begin
            emit    = 1'b1;
            raw_d   = offset_q + acc_n;
            phase_d = PH_IDLE;
          end
        end
        PH_NS_HEAD: begin
          acc_d = acc_n;
          bl_d  = bl_n;
          if (bl_n == '0) begin
            if (acc_n < thr_q) begin
              emit    = 1'b1;
              raw_d   = offset_q + acc_n;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_NS_TAIL;
            end
          end
        end
        PH_NS_TAIL: begin
          emit    = 1'b1;
          raw_d   = tail_sum[VB-1:0];
          phase_d = PH_IDLE;
        end
        default: begin
          // bits while idle are dropped
          phase_d = phase_q;
        end
      endcase
    end

    // Shared decision after a start or an escape one
    if (do_decide) begin
      offset_d = dec_offset;
      rem_d    = dec_rem;
      if (dec_ns) begin
        thr_d = dec_thr;
        bl_d  = dec_hb;
        acc_d = '0;
        if (dec_hb == '0) begin
          emit    = 1'b1;
          raw_d   = dec_offset;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_NS_HEAD;
        end
      end else begin
        phase_d = PH_PREFIX;
      end
    end
  end

  // Decoder state and finish request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pidx_q     <= '0;
      offset_q   <= '0;
      rem_q      <= '0;
      acc_q      <= '0;
      bl_q       <= '0;
      thr_q      <= '0;
      k_q        <= '0;
      job_base_q <= '0;
      job_flip_q <= 1'b0;
      job_reff_q <= '0;
      fin_q      <= '0;
      fin_raw_q  <= '0;
      fin_base_q <= '0;
      fin_reff_q <= '0;
    end else begin
      if (take) begin
        phase_q    <= phase_d;
        pidx_q     <= pidx_d;
        offset_q   <= offset_d;
        rem_q      <= rem_d;
        acc_q      <= acc_d;
        bl_q       <= bl_d;
        thr_q      <= thr_d;
        k_q        <= k_d;
        job_base_q <= job_base_d;
        job_flip_q <= job_flip_d;
        job_reff_q <= job_reff_d;
      end
      if (s2_free) begin
        fin_q.valid  <= take & emit;
        fin_q.direct <= direct;
        fin_q.flip   <= job_flip_d;
        fin_raw_q    <= raw_d;
        fin_base_q   <= job_base_d;
        fin_reff_q   <= job_reff_d;
      end
    end
  end

  assign fin_o      = fin_q;
  assign fin_raw_o  = fin_raw_q;
  assign fin_base_o = fin_base_q;
  assign fin_reff_o = fin_reff_q;

endmodule

// ===== rtl/core/subexp_recenter.sv =====
module subexp_recenter import subexp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  subexp_fin_ctl_t              fin_i,
  input  logic        [VALUE_BITS-1:0] fin_raw_i,
  input  logic        [VALUE_BITS-1:0] fin_base_i,
  input  logic signed [VALUE_BITS:0]   fin_reff_i,
  output logic                         out_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] value_o
);

  localparam int unsigned VB = VALUE_BITS;

  logic                 out_valid_q;
  logic [VB-1:0]        value_q;
  logic [VB-1:0]        value_d;
  logic                 out_ready;
  logic                 gt;
  logic [VB-1:0]        h_odd;
  logic [VB-1:0]        h_even;
  logic [VB-1:0]        u;

  assign out_ready = ~out_valid_q | ~out_stall_i;

  // Undo recentering around the reference; sums wrap at the value width
  assign gt     = $signed({2'b00, fin_raw_i}) > $signed({fin_reff_i, 1'b0});
  assign h_odd  = VB'(({1'b0, fin_raw_i} + (VB+1)'(1)) >> 1);
  assign h_even = fin_raw_i >> 1;

  always_comb begin
    if (fin_i.direct) begin
      u = '0;
    end else if (gt) begin
      u = fin_raw_i;
    end else if (fin_raw_i[0]) begin
      u = fin_reff_i[VB-1:0] - h_odd;
    end else begin
      u = fin_reff_i[VB-1:0] + h_even;
    end
    value_d = fin_i.flip ? fin_base_i - u : fin_base_i + u;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      value_q     <= '0;
    end else if (out_ready) begin
      out_valid_q <= fin_i.valid;
      value_q     <= value_d;
    end
  end

  assign out_ready_o = out_ready;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

// ===== rtl/core/subexp_with_reference_decoder_top.sv =====
// Path: a request that completes a value passes the input register, the decoder state and
// finish request register, and the output register before it shows on out_valid_o.
// Throughput: one request per cycle while out_stall_i is low; subexp_core updates its state per request.
// Requests that complete nothing (most coded bits) leave no trace at the output.
// Reset: asynchronous, active low; decoder returns to idle and all stages empty.
module subexp_with_reference_decoder_top import subexp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic                         coded_bit_i,
  input  logic signed [VALUE_BITS-1:0] low_bound_i,
  input  logic signed [VALUE_BITS-1:0] high_bound_i,
  input  logic        [3:0]            exp_k_i,
  input  logic signed [VALUE_BITS-1:0] reference_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] value_o
);

  subexp_item_ctl_t              item;
  logic        [3:0]             item_k;
  logic        [VALUE_BITS-1:0]  item_lo;
  logic        [VALUE_BITS-1:0]  item_hi_m1;
  logic signed [VALUE_BITS:0]    item_mx;
  logic signed [VALUE_BITS:0]    item_r;
  logic                          take;
  logic                          out_ready;
  subexp_fin_ctl_t               fin;
  logic        [VALUE_BITS-1:0]  fin_raw;
  logic        [VALUE_BITS-1:0]  fin_base;
  logic signed [VALUE_BITS:0]    fin_reff;

  subexp_in_stage #(.VALUE_BITS(VALUE_BITS)) u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .coded_bit_i  (coded_bit_i),
    .low_bound_i  (low_bound_i),
    .high_bound_i (high_bound_i),
    .exp_k_i      (exp_k_i),
    .reference_i  (reference_i),
    .take_i       (take),
    .item_o       (item),
    .item_k_o     (item_k),
    .item_lo_o    (item_lo),
    .item_hi_m1_o (item_hi_m1),
    .item_mx_o    (item_mx),
    .item_r_o     (item_r)
  );

  subexp_core #(.VALUE_BITS(VALUE_BITS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_k_i     (item_k),
    .item_lo_i    (item_lo),
    .item_hi_m1_i (item_hi_m1),
    .item_mx_i    (item_mx),
    .item_r_i     (item_r),
    .take_o       (take),
    .out_ready_i  (out_ready),
    .fin_o        (fin),
    .fin_raw_o    (fin_raw),
    .fin_base_o   (fin_base),
    .fin_reff_o   (fin_reff)
  );

  subexp_recenter #(.VALUE_BITS(VALUE_BITS)) u_recenter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_i       (fin),
    .fin_raw_i   (fin_raw),
    .fin_base_i  (fin_base),
    .fin_reff_i  (fin_reff),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

endmodule

// ===== bench/subexp_scoreboard_pkg.sv =====
package subexp_scoreboard_pkg;
  import subexp_pkg::*;

  localparam int unsigned VB = VALUE_BITS_DEF;

  typedef logic signed [VB-1:0] value_t;

  typedef enum {
    DEC_IDLE,
    DEC_ESCAPE,
    DEC_LITERAL,
    DEC_UNI_HEAD,
    DEC_UNI_TAIL
  } dec_phase_e;

  // Tracks the decoder state from accepted requests and holds the values it must emit
  class subexp_scoreboard;
    dec_phase_e  phase;
    int unsigned escapes;
    int unsigned k_base;
    int unsigned bits_left;
    longint      skipped;     // bucket sizes passed by escape ones
    longint      gathered;    // literal or uniform bits so far
    longint      span;        // high - low
    longint      base;        // low bound
    longint      ref_off;     // reference - low
    longint      uni_thresh;  // (1 << w) - n of the uniform code
    value_t      value_q[$];
    int          errors;
    int          checked;
    int          starts;
    int          aborts;
    int          idle_bits;

    function new();
      clear();
      errors    = 0;
      checked   = 0;
      starts    = 0;
      aborts    = 0;
      idle_bits = 0;
    endfunction

    function void clear();
      phase      = DEC_IDLE;
      escapes    = 0;
      k_base     = 0;
      bits_left  = 0;
      skipped    = 0;
      gathered   = 0;
      span       = 0;
      base       = 0;
      ref_off    = 0;
      uni_thresh = 0;
    endfunction

    function bit decoding();
      return phase != DEC_IDLE;
    endfunction

    function int pending();
      return value_q.size();
    endfunction

    function int unsigned bucket_width();
      return (escapes != 0) ? k_base + escapes - 1 : k_base;
    endfunction

    function longint unrecenter(longint r, longint v);
      if (v > 2 * r) return v;
      if ((v & 1) != 0) return r - ((v + 1) >> 1);
      return r + (v >> 1);
    endfunction

    // Undo the recentering, add the low bound, wrap to the value width
    function void emit(longint raw);
      longint x;
      if (2 * ref_off <= span) x = unrecenter(ref_off, raw);
      else x = span - 1 - unrecenter(span - 1 - ref_off, raw);
      value_q.push_back(VB'(x + base));
      phase = DEC_IDLE;
    endfunction

    // After a start or an escape step: keep escaping, or switch to the uniform tail
    function void choose_tail();
      int unsigned wb;
      int unsigned w;
      longint      n;
      wb = bucket_width();
      if (span <= skipped + longint'(SUBEXP_MULT) * (longint'(1) << wb)) begin
        n = span - skipped;
        w = 0;
        while (w < 62 && (longint'(1) << (w + 1)) <= n) w++;
        w++;
        uni_thresh = (longint'(1) << w) - n;
        bits_left  = w - 1;
        gathered   = 0;
        if (bits_left == 0) emit(skipped);
        else phase = DEC_UNI_HEAD;
      end else begin
        phase = DEC_ESCAPE;
      end
    endfunction

    function void note_request(subexp_cmd_e cmd, logic cbit, value_t lo, value_t hi,
                               logic [3:0] k, value_t center);
      int unsigned w;
      longint      b;
      b = longint'(cbit);
      if (cmd == CMD_START) begin
        starts++;
        if (phase != DEC_IDLE) aborts++;
        base      = longint'(lo);
        k_base    = k;
        ref_off   = longint'(center) - longint'(lo);
        span      = longint'(hi) - longint'(lo);
        escapes   = 0;
        skipped   = 0;
        gathered  = 0;
        bits_left = 0;
        if (span < 1) begin
          value_q.push_back(lo);
          phase = DEC_IDLE;
        end else begin
          choose_tail();
        end
        return;
      end
      case (phase)
        DEC_ESCAPE: begin
          w = bucket_width();
          if (cbit) begin
            skipped += longint'(1) << w;
            escapes++;
            choose_tail();
          end else if (w == 0) begin
            emit(skipped);
          end else begin
            bits_left = w;
            gathered  = 0;
            phase     = DEC_LITERAL;
          end
        end
        DEC_LITERAL: begin
          gathered = 2 * gathered + b;
          bits_left--;
          if (bits_left == 0) emit(skipped + gathered);
        end
        DEC_UNI_HEAD: begin
          gathered = 2 * gathered + b;
          bits_left--;
          if (bits_left == 0) begin
            if (gathered < uni_thresh) emit(skipped + gathered);
            else phase = DEC_UNI_TAIL;
          end
        end
        DEC_UNI_TAIL: begin
          emit(skipped + 2 * gathered - uni_thresh + b);
        end
        default: begin
          idle_bits++;
        end
      endcase
    endfunction

    function void check_value(value_t got);
      value_t want;
      if (value_q.size() == 0) begin
        $error("value: no result expected, got %0d", got);
        errors++;
        return;
      end
      want = value_q.pop_front();
      checked++;
      if (got !== want) begin
        $error("value: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_subexp_with_reference_decoder_top.sv =====
module tb_subexp_with_reference_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import subexp_pkg::*;
  import subexp_scoreboard_pkg::*;

  localparam int TARGET_REQUESTS = 650;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       command;
  logic       coded_bit;
  value_t     low_bound;
  value_t     high_bound;
  logic [3:0] exp_k;
  value_t     center;
  logic       out_valid;
  logic       out_stall = 1'b0;
  value_t     value;

  subexp_scoreboard sb;
  bit idle_on  = 1'b1;
  int requests = 0;
  int stall_run = 0;

  subexp_with_reference_decoder_top #(
    .VALUE_BITS(VB)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .coded_bit_i (coded_bit),
    .low_bound_i (low_bound),
    .high_bound_i(high_bound),
    .exp_k_i     (exp_k),
    .reference_i (center),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value)
  );

  always #10 clk = ~clk;

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_run > 0) stall_run--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 5);
    out_stall <= (stall_run > 0);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_value(value);
  end

  // One request: optional gap, then hold until accepted
  task automatic send_item(subexp_cmd_e cmd, logic cb, value_t lo, value_t hi,
                           logic [3:0] k, value_t rv);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    coded_bit  <= cb;
    low_bound  <= lo;
    high_bound <= hi;
    exp_k      <= k;
    center     <= rv;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_START || sb.decoding()) requests++;
    sb.note_request(cmd, cb, lo, hi, k, rv);
  endtask

  // Coded bit; the bound, k and reference fields carry noise
  task automatic send_bit(logic cb);
    send_item(CMD_BIT, cb, VB'($urandom), VB'($urandom), 4'($urandom), VB'($urandom));
  endtask

  // Start, feed the given bits (LSB first), then random bits until the value is out.
  // A cut of zero or more stops feeding after that many bits.
  task automatic run_decode(int lo, int hi, int k, int rv, logic [31:0] pat, int npat,
                            int cut);
    int i;
    i = 0;
    send_item(CMD_START, 1'($urandom), VB'(lo), VB'(hi), 4'(k), VB'(rv));
    while (sb.decoding() && (cut < 0 || i < cut)) begin
      send_bit((i < npat) ? pat[i] : 1'($urandom));
      i++;
    end
  endtask

  // Hold the sender until every expected value has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random decode with mostly small ranges and in-range references
  task automatic random_decode();
    int n;
    int lo;
    int rv;
    int k;
    int cut;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      // unconstrained bounds: empty, inverted and out-of-range references
      run_decode(int'(VB'($urandom)), int'(VB'($urandom)), $urandom_range(0, 15),
                 int'(VB'($urandom)), 0, 0, -1);
      return;
    end
    if (sel < 5) n = $urandom_range(1, 16);
    else if (sel < 8) n = $urandom_range(17, 1000);
    else n = $urandom_range(1001, 65535);
    lo = -32768 + $urandom_range(0, 65535 - n);
    if ($urandom_range(0, 6) != 0) rv = lo + $urandom_range(0, n - 1);
    else rv = int'(value_t'($urandom));
    k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 15);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
    run_decode(lo, lo + n, k, rv, 0, 0, cut);
  endtask

  initial begin
    bit drained;
    sb = new();
    drained    = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    command    <= CMD_BIT;
    coded_bit  <= 1'b0;
    low_bound  <= '0;
    high_bound <= '0;
    exp_k      <= '0;
    center     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases
    send_bit(1'b1);                                          // bit while idle
    run_decode(5, 5, 3, 5, 0, 0, -1);                        // empty range
    run_decode(32767, -32768, 15, -1, 0, 0, -1);             // inverted bounds
    run_decode(-32768, -32767, 0, -32768, 0, 0, -1);         // one symbol, done on start
    run_decode(0, 2, 0, 0, 32'b1, 1, -1);                    // uniform head only
    run_decode(0, 100, 0, 50, 32'b0, 1, -1);                 // zero-width literal
    run_decode(-32768, -32765, 0, -32766, 32'b11, 2, -1);    // uniform tail
    run_decode(-100, 1000, 2, 900, 32'b011, 3, -1);          // escapes, literal, mirrored
    run_decode(0, 4, 2, 32767, 0, 0, -1);                    // reference above range
    run_decode(0, 4, 2, -20000, 0, 0, -1);                   // reference below range
    run_decode(-1000, 20000, 0, 5, 32'b11, 2, 2);            // aborted by next start
    run_decode(-32768, 32767, 15, 0, 32'hffff, 16, -1);      // full range, largest k

    // Random part: mostly complete decodes, some noise
    while (requests < TARGET_REQUESTS) begin
      if (requests >= TARGET_REQUESTS - 90) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (!drained && requests >= TARGET_REQUESTS / 2) begin
        drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        if (sb.decoding()) random_decode();
        else repeat ($urandom_range(1, 3)) send_bit(1'($urandom));
      end else begin
        random_decode();
      end
    end
    idle_on = 1'b0;
    drain();

    $display("Run: %0d requests, %0d decodes (%0d aborted), %0d idle bits, %0d values checked",
             requests, sb.starts, sb.aborts, sb.idle_bits, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/subexp_pkg.sv
rtl/core/subexp_in_stage.sv
rtl/core/subexp_core.sv
rtl/core/subexp_recenter.sv
rtl/core/subexp_with_reference_decoder_top.sv
bench/subexp_scoreboard_pkg.sv
bench/tb_subexp_with_reference_decoder_top.sv
